[rtl/cbm_pkg.sv]
// shared types, codes and constants of the cartridge bank mapper with clock
// no dependencies
package cbm_pkg;

  // fixed bank geometry
  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_OFS_W      = $clog2(RAM_BANK_BYTES);

  // field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned MADDR_W = 21;
  localparam int unsigned RATE_W  = 24;
  localparam int unsigned ACC_W   = 23;
  localparam int unsigned DAYS_W  = 9;

  // clock rate limit
  localparam logic [RATE_W-1:0] RATE_MAX = 24'h80_0000;

  // commands
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // result targets
  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_ROM_RD  = 2'd1;
  localparam logic [1:0] TGT_RAM_RD  = 2'd2;
  localparam logic [1:0] TGT_RAM_WR  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ROM_BANKS = 2'd0;
  localparam logic [1:0] CFG_RAM_BANKS = 2'd1;
  localparam logic [1:0] CFG_TIMER     = 2'd2;
  localparam logic [1:0] CFG_RATE      = 2'd3;

  // bank select codes
  localparam logic [7:0] SEL_RAM_LAST = 8'h03;
  localparam logic [7:0] SEL_RTC_SEC  = 8'h08;
  localparam logic [7:0] SEL_RTC_MIN  = 8'h09;
  localparam logic [7:0] SEL_RTC_HRS  = 8'h0A;
  localparam logic [7:0] SEL_RTC_DLO  = 8'h0B;
  localparam logic [7:0] SEL_RTC_DHI  = 8'h0C;

  // address window codes on the top three address bits
  localparam logic [2:0] WIN_ENABLE = 3'b000;
  localparam logic [2:0] WIN_ROMSEL = 3'b001;
  localparam logic [2:0] WIN_RAMSEL = 3'b010;
  localparam logic [2:0] WIN_LATCH  = 3'b011;
  localparam logic [2:0] WIN_RAM    = 3'b101;

  // miscellaneous constants
  localparam logic [3:0] ENABLE_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS   = 8'hFF;
  localparam logic [7:0] LATCH_ARM  = 8'h00;
  localparam logic [7:0] LATCH_FIRE = 8'h01;
  localparam logic [7:0] SEC_LIMIT  = 8'd60;
  localparam logic [7:0] MIN_LIMIT  = 8'd60;
  localparam logic [7:0] HRS_LIMIT  = 8'd24;

  typedef struct packed {
    logic [7:0]        rom_bank_count;
    logic [2:0]        ram_bank_count;
    logic              timer_present;
    logic [RATE_W-1:0] rate;
  } cbm_cfg_t;

  typedef struct packed {
    logic [7:0]        seconds;
    logic [7:0]        minutes;
    logic [7:0]        hours;
    logic [DAYS_W-1:0] days;
    logic              halt;
    logic              day_carry;
  } cbm_time_t;

  typedef struct packed {
    logic              tick;
    logic              latch;
    logic              wr_en;
    logic [7:0]        wr_sel;
    logic [DATA_W-1:0] wr_data;
  } cbm_rtc_ctrl_t;

  typedef struct packed {
    logic [1:0]         target;
    logic [MADDR_W-1:0] mem_address;
    logic [DATA_W-1:0]  mem_write_data;
    logic [DATA_W-1:0]  read_data;
  } cbm_result_t;

endpackage

[rtl/cbm_cfg.sv]
// configuration register file, rate is stored already clamped
// depends on cbm_pkg
module cbm_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [cbm_pkg::RATE_W-1:0] cfg_data,
  output cbm_pkg::cbm_cfg_t         cfg
);
  import cbm_pkg::*;

  cbm_cfg_t          cfg_r;
  cbm_cfg_t          cfg_nxt;
  logic [RATE_W-1:0] rate_clamped;

  assign cfg_ready = 1'b1;
  assign cfg     = cfg_r;

  // zero behaves as one, anything above the limit as the limit
  always_comb begin
    if (cfg_data == '0) begin
      rate_clamped = RATE_W'(1);
    end else if (cfg_data > RATE_MAX) begin
      rate_clamped = RATE_MAX;
    end else begin
      rate_clamped = cfg_data;
    end
  end

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ROM_BANKS: cfg_nxt.rom_bank_count = cfg_data[7:0];
        CFG_RAM_BANKS: cfg_nxt.ram_bank_count = cfg_data[2:0];
        CFG_TIMER:     cfg_nxt.timer_present  = cfg_data[0];
        CFG_RATE:      cfg_nxt.rate           = rate_clamped;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rom_bank_count <= 8'd128;
      cfg_r.ram_bank_count <= 3'd4;
      cfg_r.timer_present  <= 1'b1;
      cfg_r.rate           <= 24'd4194304;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/cbm_rtc.sv]
// real-time clock: tick prescaler, live counters and latched copy
// depends on cbm_pkg
module cbm_rtc (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  cbm_pkg::cbm_cfg_t      cfg,
  input  cbm_pkg::cbm_rtc_ctrl_t ctrl,
  output cbm_pkg::cbm_time_t     held
);
  import cbm_pkg::*;

  cbm_time_t         live_r, live_nxt;
  cbm_time_t         held_r, held_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [RATE_W-1:0] acc_inc;
  logic [RATE_W-1:0] acc_sub;
  logic              second;
  logic [7:0]        sec_inc, min_inc, hrs_inc;
  logic [DAYS_W:0]   days_inc;

  assign held = held_r;

  // prescaler: one add and compare against the clamped rate
  always_comb begin
    acc_inc = {1'b0, acc_r} + RATE_W'(1);
    acc_sub = acc_inc - cfg.rate;
    second  = (acc_inc >= cfg.rate);
  end

  assign sec_inc  = live_r.seconds + 8'd1;
  assign min_inc  = live_r.minutes + 8'd1;
  assign hrs_inc  = live_r.hours + 8'd1;
  assign days_inc = {1'b0, live_r.days} + (DAYS_W+1)'(1);

  // next live time and accumulator
  always_comb begin
    live_nxt = live_r;
    acc_nxt  = acc_r;
    if (ctrl.tick && cfg.timer_present && !live_r.halt) begin
      if (second) begin
        acc_nxt = acc_sub[ACC_W-1:0];
        // seconds, minutes, hours, days rippled in sequence
        if (sec_inc < SEC_LIMIT) begin
          live_nxt.seconds = sec_inc;
        end else begin
          live_nxt.seconds = '0;
          if (min_inc < MIN_LIMIT) begin
            live_nxt.minutes = min_inc;
          end else begin
            live_nxt.minutes = '0;
            if (hrs_inc < HRS_LIMIT) begin
              live_nxt.hours = hrs_inc;
            end else begin
              live_nxt.hours = '0;
              if (days_inc[DAYS_W]) begin
                live_nxt.days      = '0;
                live_nxt.day_carry = 1'b1;
              end else begin
                live_nxt.days = days_inc[DAYS_W-1:0];
              end
            end
          end
        end
      end else begin
        acc_nxt = acc_inc[ACC_W-1:0];
      end
    end else if (ctrl.wr_en) begin
      // bus write to a live clock register
      case (ctrl.wr_sel)
        SEL_RTC_SEC: live_nxt.seconds = ctrl.wr_data;
        SEL_RTC_MIN: live_nxt.minutes = ctrl.wr_data;
        SEL_RTC_HRS: live_nxt.hours   = ctrl.wr_data;
        SEL_RTC_DLO: live_nxt.days    = {live_r.days[DAYS_W-1], ctrl.wr_data};
        default: begin
          live_nxt.days      = {ctrl.wr_data[0], live_r.days[DAYS_W-2:0]};
          live_nxt.halt      = ctrl.wr_data[6];
          live_nxt.day_carry = ctrl.wr_data[7];
        end
      endcase
    end
  end

  // latch takes the live time as it stands before this request
  always_comb begin
    held_nxt = held_r;
    if (ctrl.latch) begin
      held_nxt = live_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      held_r <= '0;
      acc_r  <= '0;
    end else if (fire) begin
      live_r <= live_nxt;
      held_r <= held_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

[rtl/cbm_mapper.sv]
// bus decode: bank registers, address mapping and clock register reads
// depends on cbm_pkg
module cbm_mapper (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [cbm_pkg::CMD_W-1:0]  command,
  input  logic [cbm_pkg::ADDR_W-1:0] address,
  input  logic [cbm_pkg::DATA_W-1:0] write_data,
  input  cbm_pkg::cbm_cfg_t          cfg,
  input  cbm_pkg::cbm_time_t         held,
  output cbm_pkg::cbm_rtc_ctrl_t     ctrl,
  output cbm_pkg::cbm_result_t       result
);
  import cbm_pkg::*;

  logic       enable_r, enable_nxt;
  logic [6:0] rom_bank_r, rom_bank_nxt;
  logic [7:0] select_r, select_nxt;
  logic [7:0] latch_byte_r, latch_byte_nxt;

  logic [2:0] win;
  logic [6:0] rom_phys_bank;
  logic [2:0] ram_mask;
  logic [1:0] ram_phys_bank;
  logic       ram_selected;
  logic       rtc_selected;
  logic [7:0] rtc_read;

  assign win = address[ADDR_W-1:ADDR_W-3];

  // bank arithmetic, count-1 used as a plain mask
  always_comb begin
    logic [7:0] rom_mask;
    rom_mask      = cfg.rom_bank_count - 8'd1;
    rom_phys_bank = rom_bank_r & rom_mask[6:0];
    ram_mask      = cfg.ram_bank_count - 3'd1;
    ram_phys_bank = select_r[1:0] & ram_mask[1:0];
  end

  assign ram_selected = (select_r <= SEL_RAM_LAST) && (cfg.ram_bank_count != 3'd0);
  assign rtc_selected = cfg.timer_present && (select_r >= SEL_RTC_SEC)
                        && (select_r <= SEL_RTC_DHI);

  // latched clock register read
  always_comb begin
    case (select_r)
      SEL_RTC_SEC: rtc_read = held.seconds;
      SEL_RTC_MIN: rtc_read = held.minutes;
      SEL_RTC_HRS: rtc_read = held.hours;
      SEL_RTC_DLO: rtc_read = held.days[7:0];
      default:     rtc_read = {held.day_carry, held.halt, 5'd0, held.days[DAYS_W-1]};
    endcase
  end

  // request decode
  always_comb begin
    result         = '0;
    ctrl           = '0;
    enable_nxt     = enable_r;
    rom_bank_nxt   = rom_bank_r;
    select_nxt     = select_r;
    latch_byte_nxt = latch_byte_r;
    ctrl.wr_sel    = select_r;
    ctrl.wr_data   = write_data;
    case (command)
      CMD_READ: begin
        if (address[ADDR_W-1:ADDR_W-2] == 2'b00) begin
          result.target      = TGT_ROM_RD;
          result.mem_address = MADDR_W'(address);
        end else if (address[ADDR_W-1:ADDR_W-2] == 2'b01) begin
          result.target      = TGT_ROM_RD;
          result.mem_address = {rom_phys_bank, address[ROM_OFS_W-1:0]};
        end else if (win == WIN_RAM && enable_r) begin
          if (select_r <= SEL_RAM_LAST) begin
            if (ram_selected) begin
              result.target      = TGT_RAM_RD;
              result.mem_address = MADDR_W'({ram_phys_bank, address[RAM_OFS_W-1:0]});
            end else begin
              result.read_data = OPEN_BUS;
            end
          end else if (rtc_selected) begin
            result.read_data = rtc_read;
          end else begin
            result.read_data = OPEN_BUS;
          end
        end else begin
          result.read_data = OPEN_BUS;
        end
      end
      CMD_WRITE: begin
        case (win)
          WIN_ENABLE: enable_nxt = (write_data[3:0] == ENABLE_KEY);
          WIN_ROMSEL: rom_bank_nxt = (write_data[6:0] == 7'd0) ? 7'd1 : write_data[6:0];
          WIN_RAMSEL: select_nxt = write_data;
          WIN_LATCH: begin
            ctrl.latch     = (latch_byte_r == LATCH_ARM) && (write_data == LATCH_FIRE);
            latch_byte_nxt = write_data;
          end
          WIN_RAM: begin
            if (enable_r) begin
              if (select_r <= SEL_RAM_LAST) begin
                if (ram_selected) begin
                  result.target         = TGT_RAM_WR;
                  result.mem_address    =
                    MADDR_W'({ram_phys_bank, address[RAM_OFS_W-1:0]});
                  result.mem_write_data = write_data;
                end
              end else begin
                ctrl.wr_en = rtc_selected;
              end
            end
          end
          default: ;
        endcase
      end
      CMD_TICK: ctrl.tick = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      rom_bank_r   <= 7'd1;
      select_r     <= 8'd0;
      latch_byte_r <= 8'hFF;
    end else if (fire) begin
      enable_r     <= enable_nxt;
      rom_bank_r   <= rom_bank_nxt;
      select_r     <= select_nxt;
      latch_byte_r <= latch_byte_nxt;
    end
  end

endmodule

[rtl/cartridge_bank_mapper_rtc.sv]
// top level of the cartridge bank mapper with real-time clock
// depends on cbm_pkg, cbm_cfg, cbm_mapper and cbm_rtc
//
// Usage:
//   in_*  : one request per accept (in_valid high, in_stall low): a bus read,
//           a bus write or one clock tick, with address and write data.
//   out_* : exactly one result per request, in order: target, physical
//           memory address, byte to store and the value of a read answered
//           here. Taken when out_valid is high and out_stall low.
//   cfg_* : register writes (bank counts, timer present, ticks per second);
//           cfg_ready is always high; the user writes only while the block is
//           idle, which the block itself does not enforce.
// Path: the input register takes the request when accepted, then decode and
//   state update fill the result register once out_stall lets it fire.
// Throughput: one request per cycle while out_stall is low; each request
//   reads mapper and clock state left by its predecessor via one decode stage.
// Reset: synchronous, active low; bank registers and clock counters take
//   their power-on values, both stages empty, configuration at defaults.
// Stall: with out_stall high the result register holds, the input register
//   fills and then in_stall rises; nothing is dropped.
module cartridge_bank_mapper_rtc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cbm_pkg::CMD_W-1:0]   in_command,
  input  logic [cbm_pkg::ADDR_W-1:0]  in_address,
  input  logic [cbm_pkg::DATA_W-1:0]  in_write_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_target,
  output logic [cbm_pkg::MADDR_W-1:0] out_mem_address,
  output logic [cbm_pkg::DATA_W-1:0]  out_mem_write_data,
  output logic [cbm_pkg::DATA_W-1:0]  out_read_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [cbm_pkg::RATE_W-1:0]  cfg_data
);
  import cbm_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              out_valid_r, out_valid_nxt;
  cbm_result_t       res_r;
  cbm_result_t       res;
  cbm_cfg_t          cfg;
  cbm_time_t         held;
  cbm_rtc_ctrl_t     ctrl;
  logic              fire;
  logic              in_take;

  // stage handshake
  assign fire     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !fire);
    out_valid_nxt = fire || (out_valid_r && out_stall);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= in_command;
      s1_addr_r <= in_address;
      s1_data_r <= in_write_data;
    end
  end

  cbm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cbm_mapper u_mapper (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .command    (s1_cmd_r),
    .address    (s1_addr_r),
    .write_data (s1_data_r),
    .cfg        (cfg),
    .held       (held),
    .ctrl       (ctrl),
    .result     (res)
  );

  cbm_rtc u_rtc (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cfg   (cfg),
    .ctrl  (ctrl),
    .held  (held)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_target         = res_r.target;
  assign out_mem_address    = res_r.mem_address;
  assign out_mem_write_data = res_r.mem_write_data;
  assign out_read_data      = res_r.read_data;

endmodule
